/* src/assert_macros.svh */
// Assertion helpers shared by the RTL of the factorizer.
// Concurrent checks clocked on the rising edge, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every enabled edge
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/spf_pkg.sv */
// Shared constants, table entry type and controller/datapath command codes.
// Used by spf_ctrl, spf_datapath and spf_sieve_factorizer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spf_pkg;

   localparam int TABLE_SIZE = 65536;
   // queries are 16 bits, so the table never needs more than 2^16 rows
   localparam int EFF_SIZE   = (TABLE_SIZE < 65536) ? TABLE_SIZE : 65536;
   localparam int ADDR_W     = $clog2(EFF_SIZE);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int M_W        = ADDR_W + 2;

   localparam int QUERY_W    = 16;
   localparam int PRIME_W    = 16;
   localparam int EXP_W      = 5;
   localparam int RSP_DATA_W = 24;

   // datapath operations
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_CLEAR     = 4'd1;
   localparam logic [3:0] OP_I_READ    = 4'd2;
   localparam logic [3:0] OP_I_CHECK   = 4'd3;
   localparam logic [3:0] OP_M_READ    = 4'd4;
   localparam logic [3:0] OP_M_CHECK   = 4'd5;
   localparam logic [3:0] OP_I_NEXT    = 4'd6;
   localparam logic [3:0] OP_Q_LOAD    = 4'd7;
   localparam logic [3:0] OP_Q_READ    = 4'd8;
   localparam logic [3:0] OP_Q_START   = 4'd9;
   localparam logic [3:0] OP_Q_CHECK   = 4'd10;
   localparam logic [3:0] OP_EMIT      = 4'd11;
   localparam logic [3:0] OP_EMIT_TRIV = 4'd12;

   // one table row: smallest prime factor and the cofactor n / spf(n)
   typedef struct packed {
      logic [ADDR_W-1:0] cof;
      logic [ADDR_W-1:0] spf;
   } entry_type;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic clr_last;   // counter at last table index
      logic i_prime;    // read row still unmarked
      logic i_sieve;    // i*i inside the table
      logic m_last;     // next multiple leaves the table
      logic q_trivial;  // query is 0, 1 or out of range
      logic q_last;     // remaining cofactor is 1
      logic q_same;     // read row has the current prime
      logic slot_free;  // output register can take a result
   } status_type;

endpackage
`default_nettype wire

/* src/spf_datapath.sv */
// Datapath: factor table memory, sieve counters, query registers and result register.
// Depends on spf_pkg and assert_macros.svh; driven by spf_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spf_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire spf_pkg::cmd_type               cmd,
   output spf_pkg::status_type                 status,
   input  wire logic [spf_pkg::QUERY_W-1:0]    req_tdata,   // query_value
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [spf_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // prime_factor, exponent, pad
   output logic                                rsp_tlast
);
   import spf_pkg::*;

   entry_type         mem [EFF_SIZE];
   entry_type         rd_ff;

   logic [CNT_W-1:0]  i_ff;
   logic [M_W-1:0]    m_ff;
   logic [ADDR_W-1:0] k_ff;
   logic [ADDR_W-1:0] cur_ff;
   logic [ADDR_W-1:0] p_ff;
   logic [EXP_W-1:0]  e_ff;

   logic               rsp_valid_ff;
   logic [PRIME_W-1:0] prime_ff;
   logic [EXP_W-1:0]   exp_ff;
   logic               last_ff;

   logic [2*CNT_W-1:0] sq;
   logic [M_W-1:0]     m_in;
   logic               we;
   logic [ADDR_W-1:0]  waddr;
   logic [ADDR_W-1:0]  raddr;
   entry_type          wdata;

   // status toward the controller
   assign sq   = (2*CNT_W)'(i_ff) * (2*CNT_W)'(i_ff);
   assign m_in = m_ff + M_W'(i_ff);

   always_comb begin
      status.clr_last  = (i_ff == CNT_W'(EFF_SIZE - 1));
      status.i_prime   = (rd_ff.spf == '0);
      status.i_sieve   = (sq < (2*CNT_W)'(EFF_SIZE));
      status.m_last    = (m_in >= M_W'(EFF_SIZE));
      status.q_trivial = (req_tdata < QUERY_W'(2)) || (32'(req_tdata) >= EFF_SIZE);
      status.q_last    = (cur_ff <= ADDR_W'(1));
      status.q_same    = (rd_ff.spf == p_ff);
      status.slot_free = !rsp_valid_ff || rsp_tready;
   end

   // memory port selection
   always_comb begin
      we    = 1'b0;
      waddr = i_ff[ADDR_W-1:0];
      raddr = i_ff[ADDR_W-1:0];
      wdata = '0;
      case (cmd.op)
         OP_CLEAR: begin
            we = 1'b1;
         end
         OP_I_CHECK: begin
            we        = (rd_ff.spf == '0);
            wdata.spf = i_ff[ADDR_W-1:0];
            wdata.cof = ADDR_W'(1);
         end
         OP_M_READ: begin
            raddr = m_ff[ADDR_W-1:0];
         end
         OP_M_CHECK: begin
            we        = (rd_ff.spf == '0);
            waddr     = m_ff[ADDR_W-1:0];
            wdata.spf = i_ff[ADDR_W-1:0];
            wdata.cof = k_ff;
         end
         OP_Q_READ: begin
            raddr = cur_ff;
         end
         default: begin
         end
      endcase
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   // sieve counters
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
      end else begin
         case (cmd.op)
            OP_CLEAR:   i_ff <= status.clr_last ? CNT_W'(2) : i_ff + CNT_W'(1);
            OP_I_NEXT:  i_ff <= i_ff + CNT_W'(1);
            default:    i_ff <= i_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_I_CHECK: begin
            m_ff <= M_W'(sq);
            k_ff <= i_ff[ADDR_W-1:0];
         end
         OP_M_CHECK: begin
            m_ff <= m_in;
            k_ff <= k_ff + ADDR_W'(1);
         end
         default: begin
         end
      endcase
   end

   // query walk: follow cofactors while the prime repeats
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_Q_LOAD: begin
            cur_ff <= req_tdata[ADDR_W-1:0];
         end
         OP_Q_START: begin
            p_ff   <= rd_ff.spf;
            e_ff   <= EXP_W'(1);
            cur_ff <= rd_ff.cof;
         end
         OP_Q_CHECK: begin
            if (status.q_same) begin
               e_ff   <= e_ff + EXP_W'(1);
               cur_ff <= rd_ff.cof;
            end
         end
         default: begin
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT || cmd.op == OP_EMIT_TRIV) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         prime_ff <= PRIME_W'(p_ff);
         exp_ff   <= e_ff;
         last_ff  <= status.q_last;
      end else if (cmd.op == OP_EMIT_TRIV) begin
         prime_ff <= '0;
         exp_ff   <= '0;
         last_ff  <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, exp_ff, prime_ff};
   assign rsp_tlast  = last_ff;

   `ASSERT_AT(a_zero_pair, clock, reset,
      !rsp_valid_ff || ((prime_ff == '0) == (exp_ff == '0)), "prime and exponent disagree")
   `ASSERT_AT(a_zero_last, clock, reset,
      !rsp_valid_ff || prime_ff != '0 || last_ff, "error result without last")

endmodule
`default_nettype wire

/* src/spf_ctrl.sv */
// Controller: table build sequence (clear, sieve) and query factorization steps.
// Depends on spf_pkg and assert_macros.svh; commands spf_datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire spf_pkg::status_type   status,
   output spf_pkg::cmd_type           cmd,
   input  wire logic                  req_tvalid,
   output logic                       req_tready
);
   import spf_pkg::*;

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_I_READ  = 4'd1;
   localparam logic [3:0] ST_I_CHECK = 4'd2;
   localparam logic [3:0] ST_M_READ  = 4'd3;
   localparam logic [3:0] ST_M_CHECK = 4'd4;
   localparam logic [3:0] ST_I_NEXT  = 4'd5;
   localparam logic [3:0] ST_IDLE    = 4'd6;
   localparam logic [3:0] ST_Q_READ  = 4'd7;
   localparam logic [3:0] ST_Q_START = 4'd8;
   localparam logic [3:0] ST_Q_NREAD = 4'd9;
   localparam logic [3:0] ST_Q_CHECK = 4'd10;
   localparam logic [3:0] ST_Q_EMIT  = 4'd11;
   localparam logic [3:0] ST_Q_TRIV  = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // next state and command
   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clr_last) state_in = ST_I_READ;
         end
         ST_I_READ: begin
            cmd.op   = OP_I_READ;
            state_in = ST_I_CHECK;
         end
         ST_I_CHECK: begin
            cmd.op   = OP_I_CHECK;
            state_in = (status.i_prime && status.i_sieve) ? ST_M_READ : ST_I_NEXT;
         end
         ST_M_READ: begin
            cmd.op   = OP_M_READ;
            state_in = ST_M_CHECK;
         end
         ST_M_CHECK: begin
            cmd.op   = OP_M_CHECK;
            state_in = status.m_last ? ST_I_NEXT : ST_M_READ;
         end
         ST_I_NEXT: begin
            cmd.op   = OP_I_NEXT;
            state_in = status.clr_last ? ST_IDLE : ST_I_READ;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_Q_LOAD;
               state_in = status.q_trivial ? ST_Q_TRIV : ST_Q_READ;
            end
         end
         ST_Q_READ: begin
            cmd.op   = OP_Q_READ;
            state_in = ST_Q_START;
         end
         ST_Q_START: begin
            cmd.op   = OP_Q_START;
            state_in = ST_Q_NREAD;
         end
         ST_Q_NREAD: begin
            cmd.op   = OP_Q_READ;
            state_in = ST_Q_CHECK;
         end
         ST_Q_CHECK: begin
            cmd.op   = OP_Q_CHECK;
            state_in = status.q_same ? ST_Q_NREAD : ST_Q_EMIT;
         end
         ST_Q_EMIT: begin
            if (status.slot_free) begin
               cmd.op   = OP_EMIT;
               state_in = status.q_last ? ST_IDLE : ST_Q_READ;
            end
         end
         ST_Q_TRIV: begin
            if (status.slot_free) begin
               cmd.op   = OP_EMIT_TRIV;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_m_read_check, clock, reset,
      state_ff == ST_M_READ, state_ff == ST_M_CHECK, "sieve read not followed by check")
   `ASSERT_NEXT(a_emit_done, clock, reset,
      cmd.op == OP_EMIT_TRIV, state_ff == ST_IDLE, "error result not ending query")

endmodule
`default_nettype wire

/* src/spf_sieve_factorizer.sv */
// Prime factorizer over a smallest-prime-factor table, top level.
// Depends on spf_pkg, spf_ctrl and spf_datapath.
//
// After reset the block clears its 65536-row table (one row a cycle) and then
// builds it with a sieve of Eratosthenes: each table index is read, checked
// and stepped, and each prime below 256 reads and checks its multiples from
// its square, marking those still unmarked; req_tready stays low throughout.
// Each row keeps the smallest prime factor and the cofactor, so a query walks
// the table without dividing, reading one row at a time through the single
// read port and following cofactors while the prime repeats. Each result
// waits on rsp_tready while the output register is full, and a new query is
// taken only in idle, after the last result of the previous one. One result
// per distinct prime comes out in increasing order with tlast on the final
// one; 0 and 1 give a single result with prime and exponent 0.
`timescale 1ns / 1ps
`default_nettype none
module spf_sieve_factorizer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [spf_pkg::QUERY_W-1:0]    req_tdata,   // [15:0] query_value
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [spf_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [15:0] prime_factor, [20:16] exponent
   output logic                                rsp_tlast    // last_factor
);
   import spf_pkg::*;

   cmd_type    cmd;
   status_type status;

   spf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .cmd        (cmd),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready)
   );

   spf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
